// File: hw/rtl/frame_deframer_sum16_checksum_top_defines.svh
// Assertion macros used by the frame deframer checker.
// No dependencies.
`ifndef FRAME_DEFRAMER_SUM16_CHECKSUM_TOP_DEFINES_SVH
`define FRAME_DEFRAMER_SUM16_CHECKSUM_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FDSC_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("fdsc check failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define FDSC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("fdsc check failed: next-cycle implication");

`endif

// File: hw/rtl/fdsc_pkg.sv
// Types and constants of the framed receiver with 16-bit sum checksum.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdsc_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFRAME = 3'd1;
    localparam logic [2:0] ST_GAP     = 3'd2;
    localparam logic [2:0] ST_BADSUM  = 3'd3;
    localparam logic [2:0] ST_PARITY  = 3'd4;

    localparam logic [7:0]  START_BYTE_RST = 8'h00;
    localparam logic [31:0] IDLE_LIMIT_RST = 32'hFFFF_FFFF;
    localparam logic [31:0] GAP_LIMIT_RST  = 32'h0000_FFFF;

    typedef enum logic [7:0] {
        PH_STOPPED = 8'b0000_0001,
        PH_HUNT    = 8'b0000_0010,
        PH_ID      = 8'b0000_0100,
        PH_LEN0    = 8'b0000_1000,
        PH_LEN1    = 8'b0001_0000,
        PH_DATA    = 8'b0010_0000,
        PH_SUM0    = 8'b0100_0000,
        PH_SUM1    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/fdsc_core.sv
// Frame receive state, config registers and per-word result logic.
// Depends on fdsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdsc_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fdsc_pkg::cfg_wr_t cfg_wr,
    input  wire logic              in_accept,
    input  wire logic [1:0]        in_cmd,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_perr,
    output logic                   res_valid,
    output fdsc_pkg::result_t      res
);
    import fdsc_pkg::*;

    logic [7:0]  start_byte_reg;
    logic [31:0] idle_limit_reg;
    logic [31:0] gap_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  rsum_lo_reg, rsum_lo_next;
    logic [15:0] sum_reg, sum_next;
    logic [31:0] ticks_reg, ticks_next;

    logic [31:0] ticks_inc;
    logic [15:0] sum_add;
    logic [15:0] count_inc;
    logic [15:0] len_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            idle_limit_reg <= IDLE_LIMIT_RST;
            gap_limit_reg  <= GAP_LIMIT_RST;
        end
        else if (cfg_wr.we)
        begin
            case (cfg_wr.index)
                REG_START_BYTE: start_byte_reg <= cfg_wr.data[7:0];
                REG_IDLE_LIMIT: idle_limit_reg <= cfg_wr.data;
                REG_GAP_LIMIT:  gap_limit_reg  <= cfg_wr.data;
                default:        ;
            endcase
        end
    end

    assign ticks_inc = (ticks_reg == 32'hFFFF_FFFF) ? ticks_reg : ticks_reg + 32'd1;
    assign sum_add   = sum_reg + {8'd0, in_byte};
    assign count_inc = count_reg + 16'd1;
    assign len_full  = {in_byte, len_reg[7:0]};

    always_comb
    begin
        phase_next   = phase_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        rsum_lo_next = rsum_lo_reg;
        sum_next     = sum_reg;
        ticks_next   = ticks_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.frame_id     = id_reg;
        res.frame_length = len_reg;

        if (in_cmd == CMD_ARM)
        begin
            phase_next   = PH_HUNT;
            id_next      = '0;
            len_next     = '0;
            count_next   = '0;
            rsum_lo_next = '0;
            sum_next     = '0;
            ticks_next   = '0;
        end
        else if (phase_reg != PH_STOPPED && in_cmd == CMD_TICK)
        begin
            ticks_next = ticks_inc;
            if (phase_reg == PH_HUNT)
            begin
                if (ticks_inc >= idle_limit_reg)
                begin
                    res_valid  = 1'b1;
                    res.kind   = 1'b1;
                    res.status = ST_NOFRAME;
                    phase_next = PH_STOPPED;
                end
            end
            else if (ticks_inc >= gap_limit_reg)
            begin
                res_valid  = 1'b1;
                res.kind   = 1'b1;
                res.status = ST_GAP;
                phase_next = PH_STOPPED;
            end
        end
        else if (phase_reg != PH_STOPPED && in_cmd == CMD_BYTE)
        begin
            ticks_next = '0;
            if (in_perr)
            begin
                res_valid  = 1'b1;
                res.kind   = 1'b1;
                res.status = ST_PARITY;
                phase_next = PH_STOPPED;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (in_byte == start_byte_reg)
                            phase_next = PH_ID;
                    end
                    PH_ID:
                    begin
                        id_next    = in_byte;
                        sum_next   = sum_add;
                        phase_next = PH_LEN0;
                    end
                    PH_LEN0:
                    begin
                        len_next   = {8'd0, in_byte};
                        sum_next   = sum_add;
                        phase_next = PH_LEN1;
                    end
                    PH_LEN1:
                    begin
                        len_next   = len_full;
                        sum_next   = sum_add;
                        phase_next = (len_full == 16'd0) ? PH_SUM0 : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        res_valid        = 1'b1;
                        res.kind         = 1'b0;
                        res.data_byte    = in_byte;
                        res.byte_index   = count_reg;
                        res.frame_id     = '0;
                        res.frame_length = '0;
                        sum_next         = sum_add;
                        count_next       = count_inc;
                        if (count_inc >= len_reg)
                            phase_next = PH_SUM0;
                    end
                    PH_SUM0:
                    begin
                        rsum_lo_next = in_byte;
                        phase_next   = PH_SUM1;
                    end
                    PH_SUM1:
                    begin
                        res_valid  = 1'b1;
                        res.kind   = 1'b1;
                        res.status = ({in_byte, rsum_lo_reg} == sum_reg) ? ST_OK : ST_BADSUM;
                        phase_next = PH_STOPPED;
                    end
                    default:
                        phase_next = PH_STOPPED;
                endcase
            end
        end

        if (!in_accept)
            res_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_STOPPED;
            id_reg      <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            rsum_lo_reg <= '0;
            sum_reg     <= '0;
            ticks_reg   <= '0;
        end
        else if (in_accept)
        begin
            phase_reg   <= phase_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            rsum_lo_reg <= rsum_lo_next;
            sum_reg     <= sum_next;
            ticks_reg   <= ticks_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/frame_deframer_sum16_checksum_top.sv
// Top level of the framed receiver with 16-bit sum checksum.
// Depends on fdsc_pkg and fdsc_core.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per clock on the slave side while s_tready is high: the
// frame state and checksum registers update when a word is accepted, and a
// word that yields a result has it registered into the output buffer. A
// two-word output buffer (result register plus skid register) lets input
// keep flowing while a result waits; s_tready drops only when both are full.
// Configuration writes are always ready and take effect on the next clock.
module frame_deframer_sum16_checksum_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [7:0] rx_byte, [8] parity_error, [15:9] zero
    input  wire logic [fdsc_pkg::IN_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] data_byte, [23:8] byte_index, [31:24] frame_id,
    // [47:32] frame_length, [50:48] status, [55:51] zero
    output logic [fdsc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // [0] kind
    output logic                                m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fdsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fdsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fdsc_pkg::*;

    cfg_wr_t cfg_wr;
    logic    in_accept;
    logic    res_valid;
    result_t res;

    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.we    = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;

    fdsc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .in_accept (in_accept),
        .in_cmd    (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_perr   (s_tdata[8]),
        .res_valid (res_valid),
        .res       (res)
    );

    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= res_valid;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'd0, out_reg.status, out_reg.frame_length, out_reg.frame_id,
                       out_reg.byte_index, out_reg.data_byte};

endmodule

`default_nettype wire

// File: hw/rtl/fdsc_checker.sv
// Port-level checks for the framed receiver, bound to the top level.
// Depends on fdsc_pkg and frame_deframer_sum16_checksum_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_deframer_sum16_checksum_top_defines.svh"

module fdsc_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [fdsc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                            m_tuser
);
    import fdsc_pkg::*;

    `FDSC_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `FDSC_ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `FDSC_ASSERT_SAME(a_data_word_clean, clk, rst_n, m_tvalid && !m_tuser,
        m_tdata[OUT_TDATA_W-1:24] == '0)
    `FDSC_ASSERT_SAME(a_status_word_clean, clk, rst_n, m_tvalid && m_tuser,
        m_tdata[23:0] == '0 && m_tdata[OUT_TDATA_W-1:51] == '0 && m_tdata[50:48] <= ST_PARITY)

endmodule

bind frame_deframer_sum16_checksum_top fdsc_checker u_fdsc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
